// ===== rtl/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared constants and types for the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

	localparam int ORDER_SLOTS   = 32;
	localparam int SLOT_W        = $clog2(ORDER_SLOTS);
	localparam int MAX_FILLS     = 32;
	localparam int FILL_W        = $clog2(MAX_FILLS);
	localparam logic [31:0] MARKET_OFFSET = 32'd100000;

	localparam logic [2:0] KIND_FILL      = 3'd0;
	localparam logic [2:0] KIND_DONE      = 3'd1;
	localparam logic [2:0] KIND_REJECT    = 3'd2;
	localparam logic [2:0] KIND_CANCEL_OK = 3'd3;
	localparam logic [2:0] KIND_CANCEL_NG = 3'd4;

	localparam logic OP_SUBMIT = 1'b0;
	localparam logic SIDE_BID  = 1'b0;

	typedef struct packed {
		logic [31:0] passive_id;
		logic [31:0] price;
		logic [23:0] qty;
		logic [23:0] remaining;
	} fill_rec_t;

endpackage

// ===== rtl/limit_order_book_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// Price/time priority matcher over a table of resting orders. One request is
// processed at a time by a slot scanner; results are buffered and streamed.
// Each table scan walks all ORDER_SLOTS slots over the slot memory port. A limit
// submit scans for a crossing order before each fill, then for a free slot if it
// rests and for the best prices; a market submit first scans for the best prices,
// a cancel for its id. Next request is taken after the last result is taken.
// Reset: arst_n clears all slots to empty and the arrival counter to zero.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// order_id[31:0], side[32], is_market[33], limit_price[65:34], quantity[89:66]
	input  logic [95:0]  s_tdata,
	// operation[0]
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// aggressor_id[31:0], passive_id[63:32], fill_price[95:64], fill_qty[119:96],
	// aggressor_side[120], remaining_qty[144:121], bid_px[176:145],
	// bid_present[177], ask_px[209:178], ask_present[210]
	output logic [215:0] m_tdata,
	// kind[2:0]
	output logic [2:0]   m_tuser,
	output logic         m_tlast
);
	import lobm_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MKT    = 4'd1;
	localparam logic [3:0] S_LOOP   = 4'd2;
	localparam logic [3:0] S_CROSS  = 4'd3;
	localparam logic [3:0] S_FILL   = 4'd4;
	localparam logic [3:0] S_CLOSE  = 4'd5;
	localparam logic [3:0] S_FREE   = 4'd6;
	localparam logic [3:0] S_CANCEL = 4'd7;
	localparam logic [3:0] S_BEST   = 4'd8;
	localparam logic [3:0] S_RD     = 4'd9;
	localparam logic [3:0] S_LD     = 4'd10;
	localparam logic [3:0] S_WAIT   = 4'd11;

	localparam logic [SLOT_W:0] SCAN_END = (SLOT_W+1)'(ORDER_SLOTS);
	localparam logic [FILL_W:0] FILL_END = (FILL_W+1)'(MAX_FILLS);

	logic [3:0] state_q;

	// slot table
	logic [ORDER_SLOTS-1:0] valid_q;
	logic [31:0] sl_id    [ORDER_SLOTS];
	logic        sl_side  [ORDER_SLOTS];
	logic [31:0] sl_price [ORDER_SLOTS];
	logic [23:0] sl_rem   [ORDER_SLOTS];
	logic [31:0] sl_arr   [ORDER_SLOTS];
	logic [31:0] rd_id, rd_price, rd_arr;
	logic        rd_side;
	logic [23:0] rd_rem;

	logic [SLOT_W:0]   cnt_q;
	logic              vld_s1;
	logic [SLOT_W-1:0] idx_s1;

	// request
	logic        side_q;
	logic [31:0] agg_q, lim_q;
	logic [23:0] rem_q;
	logic [31:0] arr_ctr_q;

	// scan results
	logic              pk_found_q;
	logic [SLOT_W-1:0] pk_idx_q;
	logic [31:0]       pk_price_q, pk_age_q, pk_id_q;
	logic [23:0]       pk_rem_q;
	logic              dup_q, free_found_q;
	logic [SLOT_W-1:0] free_idx_q;
	logic [31:0]       bb_q, ba_q;
	logic              bf_q, af_q;

	// results
	fill_rec_t   fmem [MAX_FILLS];
	fill_rec_t   fr_q;
	logic [FILL_W:0] n_q, k_q;
	logic [2:0]  close_kind_q;
	logic        close_side_q;
	logic [23:0] close_rem_q;

	logic [215:0] od_q;
	logic [2:0]   ok_q;
	logic         ol_q, ov_q;

	logic        e_ok, e_opp, e_cross, e_better, last_k;
	logic [31:0] e_age;
	logic [23:0] fq, rem_after;

	always_comb begin
		e_ok     = vld_s1 && valid_q[idx_s1];
		e_opp    = e_ok && (rd_side != side_q);
		e_cross  = (side_q == SIDE_BID) ? (rd_price <= lim_q) : (rd_price >= lim_q);
		e_age    = arr_ctr_q - rd_arr;
		if (!pk_found_q)
			e_better = 1'b1;
		else if (rd_price != pk_price_q)
			e_better = (side_q == SIDE_BID) ? (rd_price < pk_price_q)
			                                : (rd_price > pk_price_q);
		else
			e_better = e_age > pk_age_q;
		fq        = (rem_q < pk_rem_q) ? rem_q : pk_rem_q;
		rem_after = rem_q - fq;
		last_k    = (k_q == n_q);
	end

	wire scan_done = (cnt_q == SCAN_END) && !vld_s1;
	wire scanning  = (state_q == S_MKT) || (state_q == S_CROSS) || (state_q == S_FREE) ||
	                 (state_q == S_CANCEL) || (state_q == S_BEST);

	// slot memory: one write, one registered read
	always_ff @(posedge clk) begin
		rd_id    <= sl_id[cnt_q[SLOT_W-1:0]];
		rd_side  <= sl_side[cnt_q[SLOT_W-1:0]];
		rd_price <= sl_price[cnt_q[SLOT_W-1:0]];
		rd_rem   <= sl_rem[cnt_q[SLOT_W-1:0]];
		rd_arr   <= sl_arr[cnt_q[SLOT_W-1:0]];
		if (state_q == S_FILL)
			sl_rem[pk_idx_q] <= pk_rem_q - fq;
		else if (state_q == S_FREE && scan_done && !dup_q && free_found_q) begin
			sl_id[free_idx_q]    <= agg_q;
			sl_side[free_idx_q]  <= side_q;
			sl_price[free_idx_q] <= lim_q;
			sl_rem[free_idx_q]   <= rem_q;
			sl_arr[free_idx_q]   <= arr_ctr_q;
		end
	end

	// fill buffer
	always_ff @(posedge clk) begin
		if (state_q == S_FILL)
			fmem[n_q[FILL_W-1:0]] <= '{passive_id: pk_id_q, price: pk_price_q,
			                           qty: fq, remaining: rem_after};
		fr_q <= fmem[k_q[FILL_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			arr_ctr_q <= '0;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			ov_q      <= 1'b0;
			n_q       <= '0;
			k_q       <= '0;
		end else begin
			// a finished scan restarts the counter so a following scan runs in full
			if (scanning && !scan_done) begin
				if (cnt_q != SCAN_END) cnt_q <= cnt_q + 1'b1;
				vld_s1 <= (cnt_q != SCAN_END);
				idx_s1 <= cnt_q[SLOT_W-1:0];
			end else begin
				cnt_q  <= '0;
				vld_s1 <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						agg_q  <= s_tdata[31:0];
						side_q <= s_tdata[32];
						lim_q  <= s_tdata[65:34];
						rem_q  <= s_tdata[89:66];
						n_q    <= '0;
						bf_q   <= 1'b0;
						af_q   <= 1'b0;
						pk_found_q <= 1'b0;
						dup_q  <= 1'b0;
						free_found_q <= 1'b0;
						if (s_tuser[0] != OP_SUBMIT) state_q <= S_CANCEL;
						else if (s_tdata[33]) state_q <= S_MKT;
						else state_q <= S_LOOP;
					end
				end
				S_MKT, S_BEST: begin
					if (e_ok && rd_side == SIDE_BID && (!bf_q || rd_price > bb_q)) begin
						bb_q <= rd_price;
						bf_q <= 1'b1;
					end
					if (e_ok && rd_side != SIDE_BID && (!af_q || rd_price < ba_q)) begin
						ba_q <= rd_price;
						af_q <= 1'b1;
					end
					if (scan_done) begin
						bf_q <= 1'b0;
						af_q <= 1'b0;
						if (state_q == S_MKT) begin
							if (side_q == SIDE_BID)
								lim_q <= (af_q ? ba_q : 32'd0) + MARKET_OFFSET;
							else
								lim_q <= (bf_q ? bb_q : 32'hFFFF_FFFF) - MARKET_OFFSET;
							state_q <= S_LOOP;
						end else begin
							bf_q    <= bf_q;
							af_q    <= af_q;
							k_q     <= '0;
							state_q <= S_RD;
						end
					end
				end
				S_LOOP: begin
					pk_found_q <= 1'b0;
					state_q <= (rem_q != '0 && n_q != FILL_END) ? S_CROSS : S_CLOSE;
				end
				S_CROSS: begin
					if (e_opp && e_cross && e_better) begin
						pk_found_q <= 1'b1;
						pk_idx_q   <= idx_s1;
						pk_price_q <= rd_price;
						pk_age_q   <= e_age;
						pk_id_q    <= rd_id;
						pk_rem_q   <= rd_rem;
					end
					if (scan_done) state_q <= pk_found_q ? S_FILL : S_CLOSE;
				end
				S_FILL: begin
					if (pk_rem_q == fq) valid_q[pk_idx_q] <= 1'b0;
					rem_q   <= rem_after;
					n_q     <= n_q + 1'b1;
					state_q <= S_LOOP;
				end
				S_CLOSE: begin
					close_kind_q <= KIND_DONE;
					close_side_q <= side_q;
					close_rem_q  <= rem_q;
					dup_q        <= 1'b0;
					free_found_q <= 1'b0;
					state_q      <= (rem_q != '0) ? S_FREE : S_BEST;
				end
				S_FREE: begin
					if (e_ok && rd_id == agg_q) dup_q <= 1'b1;
					if (vld_s1 && !valid_q[idx_s1] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_s1;
					end
					if (scan_done) begin
						if (dup_q || !free_found_q)
							close_kind_q <= KIND_REJECT;
						else begin
							valid_q[free_idx_q] <= 1'b1;
							arr_ctr_q <= arr_ctr_q + 1'b1;
						end
						state_q <= S_BEST;
					end
				end
				S_CANCEL: begin
					if (e_ok && rd_id == agg_q && !pk_found_q) begin
						pk_found_q   <= 1'b1;
						pk_idx_q     <= idx_s1;
						close_side_q <= rd_side;
						close_rem_q  <= rd_rem;
					end
					if (scan_done) begin
						if (pk_found_q) begin
							valid_q[pk_idx_q] <= 1'b0;
							close_kind_q <= KIND_CANCEL_OK;
						end else begin
							close_kind_q <= KIND_CANCEL_NG;
							close_side_q <= 1'b0;
							close_rem_q  <= '0;
						end
						state_q <= S_BEST;
					end
				end
				S_RD: state_q <= S_LD;
				S_LD: begin
					if (!last_k) begin
						ok_q <= KIND_FILL;
						od_q <= {5'd0, af_q, (af_q ? ba_q : 32'd0), bf_q,
						         (bf_q ? bb_q : 32'd0), fr_q.remaining, side_q,
						         fr_q.qty, fr_q.price, fr_q.passive_id, agg_q};
					end else begin
						ok_q <= close_kind_q;
						od_q <= {5'd0, af_q, (af_q ? ba_q : 32'd0), bf_q,
						         (bf_q ? bb_q : 32'd0), close_rem_q, close_side_q,
						         24'd0, 32'd0, 32'd0, agg_q};
					end
					ol_q    <= last_k;
					ov_q    <= 1'b1;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (m_tready) begin
						ov_q <= 1'b0;
						k_q  <= k_q + 1'b1;
						state_q <= ol_q ? S_IDLE : S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ov_q;
	assign m_tdata  = od_q;
	assign m_tuser  = ok_q;
	assign m_tlast  = ol_q;

	a_valid_wait: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (state_q == S_WAIT)) else $error("result valid outside wait");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("request taken while result pending");
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= FILL_END) else $error("fill count over limit");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready) else $error("no return to idle");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the limit order book matcher. A directed table covers price
// extremes, wrapped market prices, zero quantity, duplicates, partial fills; later
// orders bring a table-full reject and the per-submit fill cap. Random order flow
// follows. Every result is checked field by field against an in-bench book.
// ----------------------------------------------------------------------------
module tb_top;
	import lobm_pkg::*;

	localparam int LIMIT = 4000000;

	typedef struct packed {
		logic        op;
		logic [31:0] id;
		logic        side;
		logic        mkt;
		logic [31:0] lim;
		logic [23:0] qty;
	} order_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] agg;
		logic [31:0] pas;
		logic [31:0] price;
		logic [23:0] fqty;
		logic        aside;
		logic [23:0] rem;
		logic [31:0] bb;
		logic        bp;
		logic [31:0] ba;
		logic        ap;
		logic        lst;
	} report_t;

	typedef struct packed {
		order_t  ord;
		logic    typed;
		report_t rpt;
	} row_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
	logic [95:0] s_tdata;
	logic [0:0] s_tuser;
	logic [215:0] m_tdata;
	logic [2:0] m_tuser;

	limit_order_book_matcher_unit dut (.*);

	// book copy
	logic        bk_valid[ORDER_SLOTS];
	logic [31:0] bk_id[ORDER_SLOTS];
	logic        bk_side[ORDER_SLOTS];
	logic [31:0] bk_price[ORDER_SLOTS];
	logic [23:0] bk_rem[ORDER_SLOTS];
	logic [31:0] bk_arr[ORDER_SLOTS];
	logic [31:0] arr_cnt;

	report_t pending_q[$];
	int errors = 0, mismatches = 0, cycles = 0, fills_seen = 0, results_seen = 0;
	int snd_idle, rcv_idle;
	int hold_left = 0;
	logic hold_go;
	logic hold_started = 1'b0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic best_price(input logic sd, output logic [31:0] p);
		logic found;
		found = 1'b0;
		p = '0;
		for (int i = 0; i < ORDER_SLOTS; i++)
			if (bk_valid[i] && bk_side[i] == sd)
				if (!found || (sd == SIDE_BID ? bk_price[i] > p : bk_price[i] < p)) begin
					p = bk_price[i];
					found = 1'b1;
				end
		return found;
	endfunction

	function automatic int best_cross(input logic sd, input logic [31:0] lim);
		int pick;
		logic better;
		logic [31:0] pp, q;
		pick = -1;
		for (int i = 0; i < ORDER_SLOTS; i++) begin
			if (!bk_valid[i] || bk_side[i] == sd) continue;
			pp = bk_price[i];
			if (sd == SIDE_BID ? pp > lim : pp < lim) continue;
			if (pick < 0) begin
				pick = i;
				continue;
			end
			q = bk_price[pick];
			if (pp != q) better = (sd == SIDE_BID) ? (pp < q) : (pp > q);
			else better = (arr_cnt - bk_arr[i]) > (arr_cnt - bk_arr[pick]);
			if (better) pick = i;
		end
		return pick;
	endfunction

	task automatic book_apply(input order_t o);
		report_t r[$];
		report_t x;
		logic [31:0] lim, bp, bb, ba;
		logic [23:0] rem, q;
		logic dup, pb, pa;
		int s, fr, n;
		lim = o.lim;
		rem = o.qty;
		n = 0;
		if (o.op == OP_SUBMIT) begin
			if (o.mkt) begin
				if (o.side == SIDE_BID) begin
					void'(best_price(1'b1, bp));
					lim = bp + MARKET_OFFSET;
				end else begin
					if (!best_price(1'b0, bp)) bp = 32'hFFFFFFFF;
					lim = bp - MARKET_OFFSET;
				end
			end
			while (rem > 0 && n < MAX_FILLS) begin
				s = best_cross(o.side, lim);
				if (s < 0) break;
				q = rem < bk_rem[s] ? rem : bk_rem[s];
				rem -= q;
				bk_rem[s] -= q;
				if (bk_rem[s] == '0) bk_valid[s] = 1'b0;
				x = '0;
				x.kind = KIND_FILL; x.agg = o.id; x.pas = bk_id[s]; x.price = bk_price[s];
				x.fqty = q; x.aside = o.side; x.rem = rem;
				r = {r, x};
				n++;
			end
			x = '0;
			x.kind = KIND_DONE; x.agg = o.id; x.aside = o.side; x.rem = rem;
			if (rem > 0) begin
				fr = -1;
				dup = 1'b0;
				for (int i = 0; i < ORDER_SLOTS; i++)
					if (bk_valid[i]) begin
						if (bk_id[i] == o.id) dup = 1'b1;
					end else if (fr < 0) fr = i;
				if (dup || fr < 0) x.kind = KIND_REJECT;
				else begin
					bk_valid[fr] = 1'b1; bk_id[fr] = o.id; bk_side[fr] = o.side;
					bk_price[fr] = lim; bk_rem[fr] = rem; bk_arr[fr] = arr_cnt;
					arr_cnt++;
				end
			end
			r = {r, x};
		end else begin
			s = -1;
			for (int i = 0; i < ORDER_SLOTS; i++)
				if (s < 0 && bk_valid[i] && bk_id[i] == o.id) s = i;
			x = '0;
			x.agg = o.id;
			if (s >= 0) begin
				bk_valid[s] = 1'b0;
				x.kind = KIND_CANCEL_OK; x.aside = bk_side[s]; x.rem = bk_rem[s];
			end else x.kind = KIND_CANCEL_NG;
			r = {r, x};
		end
		pb = best_price(1'b0, bb);
		pa = best_price(1'b1, ba);
		foreach (r[k]) begin
			r[k].bb = bb; r[k].bp = pb; r[k].ba = ba; r[k].ap = pa;
			r[k].lst = (k == r.size() - 1);
			pending_q.insert(pending_q.size(), r[k]);
		end
	endtask

	task automatic send(input order_t o, input logic typed, input report_t tr);
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, o.qty, o.lim, o.mkt, o.side, o.id};
		s_tuser <= o.op;
		do @(posedge clk); while (!s_tready);
		book_apply(o);
		if (typed) pending_q[$] = tr;
		@(negedge clk);
	endtask

	function automatic order_t rnd_order();
		order_t o;
		o.op = ($urandom_range(99) < 25);
		o.id = ($urandom_range(99) < 80) ? $urandom_range(0, 47) : $urandom;
		o.side = 1'($urandom_range(1));
		o.mkt = ($urandom_range(99) < 10);
		o.lim = ($urandom_range(99) < 85) ? 1000 + $urandom_range(0, 40) : $urandom;
		case ($urandom_range(19))
			0: o.qty = 24'($urandom_range(1, 24'hFFFFFF));
			1, 2, 3, 4: o.qty = 24'($urandom_range(1, 5000));
			default: o.qty = 24'($urandom_range(1, 20));
		endcase
		return o;
	endfunction

	function automatic order_t mk(input int unsigned op, input int unsigned id,
			input int unsigned sd, input int unsigned mkt, input int unsigned lim,
			input int unsigned qty);
		return '{op[0], id, sd[0], mkt[0], lim, qty[23:0]};
	endfunction

	function automatic report_t rp(input logic [2:0] kind, input int unsigned agg,
			input int unsigned sd, input int unsigned rem, input int unsigned bb,
			input int unsigned bp, input int unsigned ba, input int unsigned ap);
		return '{kind, agg, 32'd0, 32'd0, 24'd0, sd[0], rem[23:0], bb, bp[0], ba, ap[0],
			1'b1};
	endfunction

	// result checker
	always @(posedge clk) begin
		report_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[119:96],
				m_tdata[120], m_tdata[144:121], m_tdata[176:145], m_tdata[177],
				m_tdata[209:178], m_tdata[210], m_tlast};
			results_seen++;
			if (got.kind == KIND_FILL) fills_seen++;
			if (pending_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result %h", got);
			end else begin
				want = pending_q.pop_front();
				if (got !== want) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch\n  exp %h\n  got %h", want, got);
				end
			end
		end
	end

	// receiver, with long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else begin
			if (hold_go && !hold_started) begin
				hold_started = 1'b1;
				hold_left = 3000;
			end
			if (hold_left > 0) hold_left--;
			m_tready <= (hold_left > 0) ? 1'b0 : ($urandom_range(99) >= rcv_idle);
		end
	end

	initial begin
		row_t dir[$];
		order_t o;
		hold_go = 1'b0; snd_idle = 25; rcv_idle = 85;
		arst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
		for (int i = 0; i < ORDER_SLOTS; i++) begin
			bk_valid[i] = 1'b0; bk_id[i] = '0; bk_side[i] = 1'b0;
			bk_price[i] = '0; bk_rem[i] = '0; bk_arr[i] = '0;
		end
		arr_cnt = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		dir = '{
			'{mk(1, 5, 0, 0, 0, 0), 1'b1, rp(KIND_CANCEL_NG, 5, 0, 0, 0, 0, 0, 0)},
			'{mk(0, 0, 0, 0, 0, 'hFFFFFF), 1'b1, rp(KIND_DONE, 0, 0, 'hFFFFFF, 0, 1, 0, 0)},
			'{mk(0, 32'hFFFFFFFF, 1, 0, 32'hFFFFFFFF, 1), 1'b1,
				rp(KIND_DONE, 32'hFFFFFFFF, 1, 1, 0, 1, 32'hFFFFFFFF, 1)},
			'{mk(0, 7, 1, 1, 32'h12345678, 1), 1'b0, '0},
			'{mk(1, 32'hFFFFFFFF, 1, 1, 32'hFFFFFFFF, 'hFFFFFF), 1'b0, '0},
			'{mk(1, 0, 0, 0, 0, 0), 1'b0, '0},
			'{mk(1, 7, 0, 0, 0, 0), 1'b0, '0},
			'{mk(0, 8, 1, 1, 0, 3), 1'b0, '0},
			'{mk(0, 9, 0, 1, 32'hFFFFFFFF, 1), 1'b0, '0},
			'{mk(1, 8, 0, 0, 0, 0), 1'b0, '0},
			'{mk(1, 9, 0, 0, 0, 0), 1'b0, '0},
			'{mk(0, 10, 0, 1, 77, 2), 1'b0, '0},
			'{mk(1, 10, 0, 0, 0, 0), 1'b0, '0},
			'{mk(0, 11, 0, 0, 500, 0), 1'b1, rp(KIND_DONE, 11, 0, 0, 0, 0, 0, 0)},
			'{mk(0, 20, 1, 0, 500, 5), 1'b0, '0},
			'{mk(0, 21, 1, 0, 500, 5), 1'b0, '0},
			'{mk(0, 22, 1, 0, 490, 3), 1'b0, '0},
			'{mk(0, 30, 0, 0, 500, 10), 1'b0, '0},
			'{mk(0, 21, 0, 0, 400, 4), 1'b0, '0},
			'{mk(1, 21, 0, 0, 0, 0), 1'b0, '0},
			'{mk(0, 40, 1, 0, 1000, 2), 1'b0, '0},
			'{mk(0, 41, 0, 1, 5, 5), 1'b0, '0},
			'{mk(1, 41, 1, 0, 0, 0), 1'b0, '0}
		};
		@(negedge clk);
		foreach (dir[i]) send(dir[i].ord, dir[i].typed, dir[i].rpt);

		// fill the table, overflow it, then sweep it past the fill cap
		for (int i = 0; i < ORDER_SLOTS; i++) send(mk(0, 100 + i, 1, 0, 2000, 1), 1'b0, '0);
		send(mk(0, 150, 1, 0, 2100, 4), 1'b0, '0);
		send(mk(0, 200, 0, 0, 3000, 40), 1'b0, '0);
		send(mk(1, 200, 0, 0, 0, 0), 1'b0, '0);

		for (int ph = 0; ph < 3; ph++) begin
			s_tvalid <= 1'b0;
			while (pending_q.size() > 0) @(negedge clk);
			if (ph == 1) begin snd_idle = 85; rcv_idle = 25; end
			if (ph == 2) begin snd_idle = 0; rcv_idle = 0; hold_go = 1'b1; end
			for (int i = 0; i < 110; i++) begin
				o = rnd_order();
				send(o, 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;
		while (pending_q.size() > 0) @(posedge clk);
		repeat (1500) @(posedge clk);

		$display("covered %0d results, %0d fills, across directed book edges and random flow",
			results_seen, fills_seen);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lobm_pkg.sv
rtl/limit_order_book_matcher_unit.sv
tb/tb_top.sv
